@@ design/ilir_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared sizes, opcodes, status codes and cell control type for the
// indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

   localparam int CAPACITY = 64;
   localparam int WORD_W   = 64;
   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int OUT_CNT_W = 7;
   localparam int STS_W    = 2;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GRP_SIZE = 8;
   localparam int GRP_N    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

   localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
   localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

   // broadcast to every cell for one operation
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic             get;
      logic [CMP_W-1:0] pos;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ design/indexed_list_insert_remove.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Fixed-capacity ordered list of 64-bit words built as a chain of cells;
// push, pop, get, insert and remove, one response per request.
// ----------------------------------------------------------------------------
//  channel  direction  ports                                    transfer
//  req      in         req_opcode, req_position, req_word_in     req_valid & req_ready
//  rsp      out        rsp_word_out, rsp_count, rsp_status       rsp_valid & rsp_ready
//
//  a request is captured, executed in all cells at once, and its read data is then
//  reduced through a registered or-tree of 8-cell groups.
//  the next request is taken once the response register is loaded, so a
//  waiting response does not block it; a stalled rsp holds the reduce step.
//  synchronous reset empties the list; the words themselves are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
   import ilir_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_opcode,
   input  wire logic [POS_W-1:0]     req_position,
   input  wire logic [WORD_W-1:0]    req_word_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [WORD_W-1:0]    rsp_word_out,
   output logic      [OUT_CNT_W-1:0] rsp_count,
   output logic      [STS_W-1:0]     rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STS_W-1:0]   sts_ff, sts_in;
   logic [WORD_W-1:0]  group_ff [GRP_N];
   logic [WORD_W-1:0]  group_in [GRP_N];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;
   logic [STS_W-1:0]   rsp_sts_ff;

   logic [WORD_W-1:0]  cell_word [CAPACITY];
   logic [WORD_W-1:0]  cell_read [CAPACITY];
   logic [WORD_W-1:0]  read_word;
   cell_ctl_type       ctl;
   logic               req_xfer, rsp_load;
   logic [CMP_W-1:0]   pos_x, cnt_x, cap_x;
   logic               full, ins_go, rem_go, get_go;
   logic [CMP_W-1:0]   ins_pos;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_DRAIN) && (!rsp_valid_ff || rsp_ready);

   assign pos_x = CMP_W'(pos_ff);
   assign cnt_x = CMP_W'(count_ff);
   assign cap_x = CMP_W'(CAPACITY);
   assign full  = (cnt_x == cap_x);

   // decode and status
   always_comb begin
      ins_go   = 1'b0;
      rem_go   = 1'b0;
      get_go   = 1'b0;
      ins_pos  = pos_x;
      sts_in   = STS_DONE;
      count_in = count_ff;
      case (op_ff)
         OP_PUSH: begin
            ins_pos = cnt_x;
            if (full) begin
               sts_in = STS_FULL;
            end else begin
               ins_go   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               sts_in = STS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_GET: begin
            if (pos_x < cnt_x) begin
               get_go = 1'b1;
            end else begin
               sts_in = STS_RANGE;
            end
         end
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               sts_in = STS_RANGE;
            end else if (full) begin
               sts_in = STS_FULL;
            end else begin
               ins_go   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (pos_x >= cnt_x) begin
               sts_in = STS_RANGE;
            end else begin
               rem_go   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            sts_in = STS_DONE;
         end
      endcase
   end

   always_comb begin
      ctl.ins = (state_ff == S_EXEC) && ins_go;
      ctl.rem = (state_ff == S_EXEC) && rem_go;
      ctl.get = (state_ff == S_EXEC) && get_go;
      ctl.pos = ins_pos;
   end

   // the cell chain
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [WORD_W-1:0] lo_word;
      logic [WORD_W-1:0] hi_word;
      if (k == 0) begin : g_first
         assign lo_word = '0;
      end else begin : g_mid_lo
         assign lo_word = cell_word[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign hi_word = '0;
      end else begin : g_mid_hi
         assign hi_word = cell_word[k+1];
      end
      ilir_cell u_cell (
         .clock    (clock),
         .cell_idx (IDX_W'(k)),
         .ctl      (ctl),
         .word_new (word_ff),
         .word_lo  (lo_word),
         .word_hi  (hi_word),
         .word_q   (cell_word[k]),
         .read_q   (cell_read[k])
      );
   end

   // first level of the read tree
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            if (g * GRP_SIZE + j < CAPACITY) begin
               group_in[g] = group_in[g] | cell_read[g * GRP_SIZE + j];
            end
         end
      end
   end

   always_comb begin
      read_word = '0;
      for (int g = 0; g < GRP_N; g++) begin
         read_word = read_word | group_ff[g];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff   <= req_opcode;
         pos_ff  <= req_position;
         word_ff <= req_word_in;
      end
      if (state_ff == S_EXEC) begin
         sts_ff <= sts_in;
         for (int g = 0; g < GRP_N; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
      if (rsp_load) begin
         rsp_word_ff  <= read_word;
         rsp_count_ff <= OUT_CNT_W'(count_ff);
         rsp_sts_ff   <= sts_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_sts_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("list count above capacity");

   a_req_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_EXEC)
      else $error("accepted request not executed next cycle");

   a_fail_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_DONE |-> rsp_word_out == '0)
      else $error("failed operation returned a word");

   a_exec_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.ins, ctl.rem, ctl.get}))
      else $error("more than one cell action at once");

endmodule

`default_nettype wire

@@ design/ilir_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_cell
// One list entry: holds a word, takes the new word or its lower neighbor's
// word on insert, its upper neighbor's on remove, and drives it when read.
// ----------------------------------------------------------------------------
module ilir_cell
   import ilir_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [IDX_W-1:0]  cell_idx,
   input  wire cell_ctl_type      ctl,
   input  wire logic [WORD_W-1:0] word_new,
   input  wire logic [WORD_W-1:0] word_lo,
   input  wire logic [WORD_W-1:0] word_hi,
   output logic      [WORD_W-1:0] word_q,
   output logic      [WORD_W-1:0] read_q
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic [CMP_W-1:0]  idx_x;

   assign idx_x = CMP_W'(cell_idx);

   always_comb begin
      word_in = word_ff;
      if (ctl.ins) begin
         if (idx_x > ctl.pos) begin
            word_in = word_lo;
         end else if (idx_x == ctl.pos) begin
            word_in = word_new;
         end
      end else if (ctl.rem) begin
         if (idx_x >= ctl.pos) begin
            word_in = word_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_q = word_ff;
   assign read_q = (ctl.get && idx_x == ctl.pos) ? word_ff : '0;

endmodule

`default_nettype wire

@@ bench/list_reply_checker.sv @@
// ----------------------------------------------------------------------------
// list_reply_checker
// Watches the request and response channels of the indexed list, keeps a
// shadow copy of the stored words and length, predicts one reply per
// accepted request and compares each returned reply field by field.
// ----------------------------------------------------------------------------
module list_reply_checker
   import ilir_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [OP_W-1:0]      req_opcode,
   input  wire logic [POS_W-1:0]     req_position,
   input  wire logic [WORD_W-1:0]    req_word_in,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [WORD_W-1:0]    rsp_word_out,
   input  wire logic [OUT_CNT_W-1:0] rsp_count,
   input  wire logic [STS_W-1:0]     rsp_status,
   output int                        fail_count,
   output int                        pending,
   output int                        len_hint,
   output logic [3:0][31:0]          status_seen
);

   typedef struct packed {
      logic [WORD_W-1:0]    word;
      logic [OUT_CNT_W-1:0] count;
      logic [STS_W-1:0]     status;
   } list_reply_type;

   logic [WORD_W-1:0] shadow_words [CAPACITY];
   int                shadow_len = 0;
   list_reply_type    expected_replies [$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      len_hint    = 0;
      status_seen = '0;
   end

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word, output list_reply_type r);
      int p;
      p = int'(pos);
      r = '0;
      r.status = STS_DONE;
      case (op)
         OP_PUSH: begin
            if (shadow_len >= CAPACITY) r.status = STS_FULL;
            else begin
               shadow_words[shadow_len] = word;
               shadow_len++;
            end
         end
         OP_POP: begin
            if (shadow_len == 0) r.status = STS_EMPTY;
            else shadow_len--;
         end
         OP_GET: begin
            if (p < shadow_len) r.word = shadow_words[p];
            else r.status = STS_RANGE;
         end
         OP_INSERT: begin
            if (p > shadow_len) r.status = STS_RANGE;
            else if (shadow_len >= CAPACITY) r.status = STS_FULL;
            else begin
               for (int k = shadow_len; k > p; k--) shadow_words[k] = shadow_words[k-1];
               shadow_words[p] = word;
               shadow_len++;
            end
         end
         OP_REMOVE: begin
            if (p >= shadow_len) r.status = STS_RANGE;
            else begin
               for (int k = p; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
               shadow_len--;
            end
         end
         default: ;
      endcase
      r.count = OUT_CNT_W'(shadow_len);
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got_reply;
      if (reset) begin
         shadow_len = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with no request outstanding", rsp_word_out, '0);
            end else begin
               want = expected_replies.pop_front();
               status_seen[want.status] <= status_seen[want.status] + 1;
               if (rsp_word_out !== want.word)
                  report_mismatch("word_out", rsp_word_out, want.word);
               if (rsp_count !== want.count)
                  report_mismatch("count", WORD_W'(rsp_count), WORD_W'(want.count));
               if (rsp_status !== want.status)
                  report_mismatch("status", WORD_W'(rsp_status), WORD_W'(want.status));
            end
         end
         if (req_valid && req_ready) begin
            apply_list_op(req_opcode, req_position, req_word_in, got_reply);
            expected_replies.push_back(got_reply);
         end
      end
      pending  <= expected_replies.size();
      len_hint <= shadow_len;
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives push, pop, get, insert, remove and unused opcodes into the indexed
// list: a short directed sequence, then random runs that each tend to fill,
// drain or mix the list, under random idling on both channels and one long
// response hold-off. Checking is done by list_reply_checker.
// ----------------------------------------------------------------------------
module tb
   import ilir_pkg::*;
();

   localparam int RANDOM_ITEMS = 1930;
   localparam int PHASE_ONE_END = 640;
   localparam int PHASE_TWO_END = 1280;
   localparam int HOLD_AT = 1500;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   typedef enum int {GROW, SHRINK, MIXED} trend_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_opcode = OP_PUSH;
   logic [POS_W-1:0]     req_position = '0;
   logic [WORD_W-1:0]    req_word_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_W-1:0]    rsp_word_out;
   logic [OUT_CNT_W-1:0] rsp_count;
   logic [STS_W-1:0]     rsp_status;

   int               fail_count;
   int               pending;
   int               len_hint;
   logic [3:0][31:0] status_seen;

   int   send_idle_pct = 23;
   int   rcv_idle_pct = 69;
   int   sent_count = 0;
   int   cycles = 0;
   logic hold_off = 1'b0;

   indexed_list_insert_remove dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_out (rsp_word_out),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

   list_reply_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_out (rsp_word_out),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status),
      .fail_count   (fail_count),
      .pending      (pending),
      .len_hint     (len_hint),
      .status_seen  (status_seen)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // long response stall while requests keep coming
   initial begin
      wait (sent_count >= HOLD_AT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_word_in  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [OP_W-1:0] pick_unused_opcode();
      return OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
   endfunction

   function automatic logic [OP_W-1:0] pick_opcode(trend_type trend);
      int roll;
      int cut_push;
      int cut_ins;
      int cut_get;
      int cut_pop;
      roll = $urandom_range(99);
      case (trend)
         GROW:    begin cut_push = 38; cut_ins = 78; cut_get = 88; cut_pop = 94; end
         SHRINK:  begin cut_push = 10; cut_ins = 18; cut_get = 33; cut_pop = 66; end
         default: begin cut_push = 22; cut_ins = 41; cut_get = 60; cut_pop = 80; end
      endcase
      if (roll < 3) return pick_unused_opcode();
      if (roll < cut_push) return OP_PUSH;
      if (roll < cut_ins) return OP_INSERT;
      if (roll < cut_get) return OP_GET;
      if (roll < cut_pop) return OP_POP;
      return OP_REMOVE;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(int len);
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return POS_W'($urandom_range(len));
      if (roll < 78) return POS_W'(len);
      if (roll < 86) return POS_W'((len < 127) ? len + 1 : len);
      if (roll < 90) return POS_W'(CAPACITY - 1 + $urandom_range(1));
      return POS_W'($urandom_range(127));
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '1;
      if (roll < 10) return '0;
      return {$urandom, $urandom};
   endfunction

   initial begin
      trend_type trend;
      int        run_left;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners, then a short list: inserts, gets, removes and unused opcodes
      send_item(OP_POP, '0, '0);
      send_item(OP_GET, '0, '1);
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_INSERT, 7'd1, 64'h1111_2222_3333_4444);
      send_item(OP_INSERT, '0, '1);
      send_item(OP_PUSH, '1, '0);
      send_item(OP_PUSH, '0, 64'hA5A5_5A5A_C3C3_3C3C);
      send_item(OP_INSERT, 7'd1, 64'h0123_4567_89AB_CDEF);
      send_item(OP_INSERT, '0, 64'h8000_0000_0000_0001);
      for (int i = 0; i < 5; i++) send_item(OP_GET, POS_W'(i), '0);
      send_item(OP_GET, '1, '1);
      send_item(OP_REMOVE, 7'd1, '0);
      send_item(OP_REMOVE, 7'd3, '0);
      send_item(OP_REMOVE, 7'd64, '0);
      send_item(OP_UNUSED_FIRST, 7'd2, '1);
      send_item(OP_UNUSED_LAST, '1, 64'hFFFF_0000_FFFF_0000);
      send_item(OP_POP, 7'd5, '1);
      send_item(OP_GET, 7'd1, '0);

      run_left = 0;
      trend = GROW;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PHASE_ONE_END) begin
            send_idle_pct = 69;
            rcv_idle_pct <= 23;
         end
         if (n == PHASE_TWO_END) begin
            send_idle_pct = 0;
            rcv_idle_pct <= 0;
         end
         if (run_left == 0) begin
            run_left = $urandom_range(120, 20);
            case ($urandom_range(4))
               0, 1:    trend = GROW;
               2, 3:    trend = SHRINK;
               default: trend = MIXED;
            endcase
         end
         run_left--;
         send_item(pick_opcode(trend), pick_position(len_hint), pick_word());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("%0d requests sent and %0d replies checked",
               sent_count, status_seen[STS_DONE] + status_seen[STS_RANGE] +
               status_seen[STS_FULL] + status_seen[STS_EMPTY]);
      $display("status mix: done %0d, out of range %0d, full refused %0d, empty pop %0d",
               status_seen[STS_DONE], status_seen[STS_RANGE], status_seen[STS_FULL],
               status_seen[STS_EMPTY]);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/ilir_pkg.sv
design/ilir_cell.sv
design/indexed_list_insert_remove.sv
bench/list_reply_checker.sv
bench/tb.sv
